>>> hw/rtl/ps2m_pkg.sv
// Package for the PS/2 mouse packet decoder: event codes, button codes,
// the packet record handed from the byte collector to the result emitter.
// No dependencies.
`default_nettype none

package ps2m_pkg;

    // Result kinds carried on the master tuser
    typedef enum logic [1:0] {
        EV_MOVE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } t_event_kind;

    // Button numbers, bit positions of the header's low three bits
    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_RIGHT  = 2'd1;
    localparam logic [1:0] BTN_MIDDLE = 2'd2;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int MOVE_X_W = 9;
    localparam int MOVE_Y_W = 10;
    localparam int BTN_N    = 3;

    // Header bit that marks a valid first byte, and the sign bits
    localparam int HDR_SYNC_BIT = 3;
    localparam int HDR_XSIGN    = 4;
    localparam int HDR_YSIGN    = 5;

    // Completed packet, ready to be turned into results
    typedef struct packed {
        logic                       emit;   // a packet completed on this beat
        logic signed [MOVE_X_W-1:0] mx;
        logic signed [MOVE_Y_W-1:0] my;
        logic [BTN_N-1:0]           now;    // new button state
        logic [BTN_N-1:0]           diff;   // buttons that changed
    } t_pkt;

    // X: the byte with the header sign bit above it is already two's complement
    function automatic logic signed [MOVE_X_W-1:0] f_move_x(
        input logic [BYTE_W-1:0] hdr,
        input logic [BYTE_W-1:0] xb
    );
        f_move_x = $signed({hdr[HDR_XSIGN], xb});
    endfunction

    // Y: sign extend to ten bits, then negate for screen direction
    function automatic logic signed [MOVE_Y_W-1:0] f_move_y(
        input logic [BYTE_W-1:0] hdr,
        input logic [BYTE_W-1:0] yb
    );
        logic [MOVE_Y_W-1:0] v;
        v = {hdr[HDR_YSIGN], hdr[HDR_YSIGN], yb};
        f_move_y = $signed(MOVE_Y_W'(~v + 1'b1));
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ps2m_collect.sv
// Byte collector for the PS/2 mouse decoder: gathers header, X, Y and the
// optional wheel byte, keeps the button state. Uses ps2m_pkg.
`default_nettype none

module ps2m_collect
    import ps2m_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,     // a byte is taken this cycle
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_four_byte,
    output t_pkt                   o_pkt         // valid in the accepting cycle
);

    logic [1:0]        r_held,  n_held;
    logic [BYTE_W-1:0] r_hdr,   n_hdr;
    logic [BYTE_W-1:0] r_x,     n_x;
    logic [BYTE_W-1:0] r_y,     n_y;
    logic [BTN_N-1:0]  r_btn,   n_btn;

    logic [BYTE_W-1:0] ybyte;
    logic              done;

    // Next state and packet decode
    always_comb begin
        n_held = r_held;
        n_hdr  = r_hdr;
        n_x    = r_x;
        n_y    = r_y;
        n_btn  = r_btn;
        done   = 1'b0;
        ybyte  = r_y;
        unique case (r_held)
            2'd0: begin
                if (i_byte[HDR_SYNC_BIT]) begin
                    n_hdr  = i_byte;
                    n_held = 2'd1;
                end
            end
            2'd1: begin
                n_x    = i_byte;
                n_held = 2'd2;
            end
            2'd2: begin
                n_y   = i_byte;
                ybyte = i_byte;
                if (i_four_byte) begin
                    n_held = 2'd3;
                end else begin
                    done   = 1'b1;
                    n_held = 2'd0;
                end
            end
            default: begin
                // wheel byte is dropped; with the mode cleared it may open a packet
                done   = 1'b1;
                n_held = 2'd0;
                if (!i_four_byte && i_byte[HDR_SYNC_BIT]) begin
                    n_hdr  = i_byte;
                    n_held = 2'd1;
                end
            end
        endcase
        if (done) begin
            n_btn = r_hdr[BTN_N-1:0];
        end

        o_pkt.emit = i_accept & done;
        o_pkt.mx   = f_move_x(r_hdr, r_x);
        o_pkt.my   = f_move_y(r_hdr, ybyte);
        o_pkt.now  = r_hdr[BTN_N-1:0];
        o_pkt.diff = r_hdr[BTN_N-1:0] ^ r_btn;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_hdr  <= '0;
            r_x    <= '0;
            r_y    <= '0;
            r_btn  <= '0;
        end else if (i_accept) begin
            r_held <= n_held;
            r_hdr  <= n_hdr;
            r_x    <= n_x;
            r_y    <= n_y;
            r_btn  <= n_btn;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ps2_mouse_packet_decoder.sv
// Top level of the PS/2 mouse packet decoder: stream ports, mode register
// and result emitter. Uses ps2m_pkg and ps2m_collect.
`default_nettype none

// Takes one mouse byte per slave beat and emits, for each complete packet,
// one movement result followed by a press or release result for each of
// left, right and middle that changed, the final one flagged by tlast.
// Bytes that complete no packet are taken one per cycle while no results
// are pending. A byte that completes a packet loads the pending-packet
// register, and its results leave it one per cycle while the master is
// ready, one to four beats; the next byte is taken in the cycle its last
// result goes out. The four-byte mode register is written through the cfg
// channel, which is always ready, and should only change while idle.
module ps2_mouse_packet_decoder
    import ps2m_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // mode register write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,     // four_byte_packets
    // byte input
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,      // [7:0] data_byte
    // result output
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,      // [8:0] move_x, [18:9] move_y,
                                             // [20:19] button, [23:21] zero
    output logic [1:0]       o_m_tuser,      // [1:0] event_kind
    output logic             o_m_tlast       // last result of this byte
);

    logic       r_four_byte;
    logic       s_acc;
    logic       m_acc;
    t_pkt       pkt;

    // pending packet
    logic                       r_busy;
    logic                       r_mov;      // movement beat still to go
    logic [BTN_N-1:0]           r_diff;     // button beats still to go
    logic [BTN_N-1:0]           r_now;
    logic signed [MOVE_X_W-1:0] r_mx;
    logic signed [MOVE_Y_W-1:0] r_my;

    logic [1:0]       cur_btn;
    logic [BTN_N-1:0] cur_mask;
    logic             cur_last;
    t_event_kind      cur_kind;

    assign o_cfg_ready = 1'b1;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_byte <= 1'b0;
        end else if (i_cfg_valid) begin
            r_four_byte <= i_cfg_data;
        end
    end

    ps2m_collect u_collect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_acc),
        .i_byte      (i_s_tdata),
        .i_four_byte (r_four_byte),
        .o_pkt       (pkt)
    );

    // Pick the current beat: movement first, then lowest changed button
    always_comb begin
        cur_btn  = BTN_LEFT;
        cur_mask = 3'b001;
        if (!r_diff[BTN_LEFT]) begin
            if (r_diff[BTN_RIGHT]) begin
                cur_btn  = BTN_RIGHT;
                cur_mask = 3'b010;
            end else begin
                cur_btn  = BTN_MIDDLE;
                cur_mask = 3'b100;
            end
        end
        if (r_mov) begin
            cur_kind = EV_MOVE;
            cur_last = (r_diff == '0);
        end else begin
            cur_kind = ((r_now & cur_mask) != '0) ? EV_PRESS : EV_RELEASE;
            cur_last = ((r_diff & ~cur_mask) == '0);
        end
    end

    assign o_m_tvalid = r_busy;
    assign m_acc      = r_busy & i_m_tready;
    assign o_s_tready = !r_busy || (i_m_tready && cur_last);
    assign s_acc      = i_s_tvalid & o_s_tready;

    assign o_m_tuser  = cur_kind;
    assign o_m_tlast  = cur_last;
    assign o_m_tdata  = r_mov ? {5'd0, r_my, r_mx}
                              : {3'd0, cur_btn, {MOVE_Y_W{1'b0}}, {MOVE_X_W{1'b0}}};

    // Pending packet: load on a completing byte, retire one beat per handshake.
    // A completing byte is only taken while idle or alongside the last beat, so loading wins.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mov  <= 1'b0;
            r_diff <= '0;
        end else if (pkt.emit) begin
            r_busy <= 1'b1;
            r_mov  <= 1'b1;
            r_diff <= pkt.diff;
        end else if (m_acc) begin
            if (r_mov) begin
                r_mov <= 1'b0;
            end else begin
                r_diff <= r_diff & ~cur_mask;
            end
            if (cur_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pkt.emit) begin
            r_mx  <= pkt.mx;
            r_my  <= pkt.my;
            r_now <= pkt.now;
        end
    end

endmodule

`default_nettype wire
